// ===== src/positional_list_insert_delete_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional list block
// Concurrent checks on the rising edge of i_clk, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PLID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plid assertion failed");

// next-cycle implication
`define PLID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plid assertion failed");

`else

`define PLID_ASSERT_IMP(label, ante, cons)
`define PLID_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/plid_pkg.sv =====
// ----------------------------------------------------------------------------
// plid_pkg
// Field types, command and status codes and sequencer states of the list.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef logic        [MODE_W-1:0]   t_mode;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic signed [POS_W-1:0]    t_pos;
    typedef logic        [STATUS_W-1:0] t_status;
    typedef logic        [COUNT_W-1:0]  t_count;

    localparam t_mode MODE_INS_FRONT = 3'd0;
    localparam t_mode MODE_INS_BACK  = 3'd1;
    localparam t_mode MODE_INS_POS   = 3'd2;
    localparam t_mode MODE_DEL_FRONT = 3'd3;
    localparam t_mode MODE_DEL_BACK  = 3'd4;
    localparam t_mode MODE_DEL_POS   = 3'd5;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_NEGATIVE = 3'd2;
    localparam t_status ST_RANGE    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_PUT,
        S_RD_FIRST,
        S_RD_LAST,
        S_GRAB,
        S_DONE
    } t_state;

endpackage

// ===== src/plid_if.sv =====
// ----------------------------------------------------------------------------
// plid channel interfaces
// Command and response channels, valid/ready, one beat per item.
// ----------------------------------------------------------------------------
interface plid_cmd_if;
    logic              valid;
    logic              ready;
    plid_pkg::t_mode   mode;
    plid_pkg::t_value  value;
    plid_pkg::t_pos    position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface plid_rsp_if;
    logic               valid;
    logic               ready;
    plid_pkg::t_status  status;
    plid_pkg::t_count   count;
    plid_pkg::t_value   first_value;
    plid_pkg::t_value   last_value;

    modport source (output valid, output status, output count, output first_value,
                    output last_value, input ready);
    modport sink   (input valid, input status, input count, input first_value,
                    input last_value, output ready);
endinterface

// ===== src/plid_mem.sv =====
// ----------------------------------------------------------------------------
// plid_mem
// List storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plid_mem #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed values with insert/delete at front, back or position.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY entries of DATA_WIDTH bits in a memory with
// one read and one write port; position 0 is the front. One command beat is
// taken at a time and gives exactly one response beat: status, count after the
// command and the front and back values (zero when empty). Entries behind an
// insert or delete point are moved one place per cycle through the memory's
// read and write ports, so the memory sets the rate. From the command beat to
// the response turning valid there is a decode step, the moving, the write of
// the new entry on inserts, the read-back of the front and back (skipped when
// the list ends empty) and the registering of the response, plus any wait for
// the previous response to be taken. A refused command or an unused mode
// skips the moving, and the longest command is a front insert or delete that
// moves CAPACITY - 1 entries. The block takes a new command as soon as the
// previous one has its response registered, even if that response has not
// yet been taken. Inserts into a full list are refused with status full, but
// a position insert at a negative position gets status negative. Values are
// cut or sign-extended to DATA_WIDTH when stored and back to 32 bits when
// shown. Stored entries need no reset; only entries below the count are read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plid_cmd_if.sink    i_cmd,
    plid_rsp_if.source  o_rsp
);

    `include "positional_list_insert_delete_assert.svh"

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = plid_pkg::POS_W;
    localparam int VW    = plid_pkg::VALUE_W;
    localparam int CW    = plid_pkg::COUNT_W;
    localparam int CMP_W = ((OCC_W > PW) ? OCC_W : PW) + 1;

    // control
    plid_pkg::t_state r_state, n_state;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic             r_out_valid, n_out_valid;
    logic             r_wpend, n_wpend;

    // captured command and working registers
    plid_pkg::t_mode          r_mode, n_mode;
    logic signed [DATA_WIDTH-1:0] r_value, n_value;
    plid_pkg::t_pos           r_pos, n_pos;
    plid_pkg::t_status        r_status, n_status;
    logic                     r_ins, n_ins;     // shift direction: towards back
    logic [OCC_W-1:0]         r_idx, n_idx;     // running index of the move
    logic [OCC_W-1:0]         r_stop, n_stop;   // index where moving stops
    logic [AW-1:0]            r_waddr, n_waddr; // pending moved-entry target
    plid_pkg::t_value         r_first, n_first;
    plid_pkg::t_value         r_last, n_last;

    // response register
    plid_pkg::t_status r_out_status, n_out_status;
    plid_pkg::t_count  r_out_count, n_out_count;
    plid_pkg::t_value  r_out_first, n_out_first;
    plid_pkg::t_value  r_out_last, n_out_last;

    // memory port
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [DATA_WIDTH-1:0]        w_wdata;
    logic [AW-1:0]                w_raddr;
    logic signed [DATA_WIDTH-1:0] w_rdata;

    // decode helpers
    logic             w_full, w_empty, w_neg, w_more, w_rsp_free;
    logic [CMP_W-1:0] w_pos_ext, w_occ_ext;
    logic [OCC_W-1:0] w_pos_idx, w_idx_step;

    assign w_full     = (r_occ >= OCC_W'(CAPACITY));
    assign w_empty    = (r_occ == '0);
    assign w_neg      = r_pos[PW-1];
    assign w_pos_ext  = CMP_W'(unsigned'(r_pos));
    assign w_occ_ext  = CMP_W'(r_occ);
    assign w_pos_idx  = OCC_W'(unsigned'(r_pos));
    assign w_more     = (r_idx != r_stop);
    assign w_rsp_free = !r_out_valid || o_rsp.ready;
    // index step of one: down towards the front on inserts, up on deletes
    assign w_idx_step = r_ins ? (r_idx - OCC_W'(1)) : (r_idx + OCC_W'(1));

    plid_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            plid_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = plid_pkg::S_DECODE;
                end
            end
            plid_pkg::S_DECODE: begin
                n_state = plid_pkg::S_RD_FIRST;
                case (r_mode)
                    plid_pkg::MODE_INS_FRONT, plid_pkg::MODE_INS_BACK: begin
                        if (!w_full) begin
                            n_state = plid_pkg::S_SHIFT;
                        end
                    end
                    plid_pkg::MODE_INS_POS: begin
                        if (!w_neg && !w_full && !(w_pos_ext > w_occ_ext)) begin
                            n_state = plid_pkg::S_SHIFT;
                        end
                    end
                    plid_pkg::MODE_DEL_FRONT, plid_pkg::MODE_DEL_BACK: begin
                        if (!w_empty) begin
                            n_state = plid_pkg::S_SHIFT;
                        end
                    end
                    plid_pkg::MODE_DEL_POS: begin
                        if (!w_empty && !w_neg && (w_pos_ext < w_occ_ext)) begin
                            n_state = plid_pkg::S_SHIFT;
                        end
                    end
                    default: begin
                        n_state = plid_pkg::S_RD_FIRST;
                    end
                endcase
            end
            plid_pkg::S_SHIFT: begin
                if (!w_more && !r_wpend) begin
                    n_state = r_ins ? plid_pkg::S_PUT : plid_pkg::S_RD_FIRST;
                end
            end
            plid_pkg::S_PUT: begin
                n_state = plid_pkg::S_RD_FIRST;
            end
            plid_pkg::S_RD_FIRST: begin
                n_state = w_empty ? plid_pkg::S_DONE : plid_pkg::S_RD_LAST;
            end
            plid_pkg::S_RD_LAST: begin
                n_state = plid_pkg::S_GRAB;
            end
            plid_pkg::S_GRAB: begin
                n_state = plid_pkg::S_DONE;
            end
            plid_pkg::S_DONE: begin
                if (w_rsp_free) begin
                    n_state = plid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plid_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs: handshake and memory port
    // ------------------------------------------------------------------------
    always_comb begin
        i_cmd.ready = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_waddr;
        w_wdata     = w_rdata;
        w_raddr     = '0;
        case (r_state)
            plid_pkg::S_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            plid_pkg::S_SHIFT: begin
                // read the entry to move; write the one read last cycle
                w_raddr = r_ins ? AW'(r_idx - OCC_W'(1)) : AW'(r_idx);
                w_we    = r_wpend;
            end
            plid_pkg::S_PUT: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_stop);
                w_wdata = r_value;
            end
            plid_pkg::S_RD_LAST: begin
                w_raddr = AW'(r_occ - OCC_W'(1));
            end
            default: begin
                w_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------------
    always_comb begin
        n_occ        = r_occ;
        n_wpend      = r_wpend;
        n_mode       = r_mode;
        n_value      = r_value;
        n_pos        = r_pos;
        n_status     = r_status;
        n_ins        = r_ins;
        n_idx        = r_idx;
        n_stop       = r_stop;
        n_waddr      = r_waddr;
        n_first      = r_first;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;

        case (r_state)
            plid_pkg::S_IDLE: begin
                n_mode  = i_cmd.mode;
                n_value = DATA_WIDTH'(i_cmd.value);
                n_pos   = i_cmd.position;
            end
            plid_pkg::S_DECODE: begin
                n_status = plid_pkg::ST_OK;
                n_wpend  = 1'b0;
                case (r_mode)
                    plid_pkg::MODE_INS_FRONT, plid_pkg::MODE_INS_BACK,
                    plid_pkg::MODE_INS_POS: begin
                        n_ins  = 1'b1;
                        n_idx  = r_occ;
                        n_stop = (r_mode == plid_pkg::MODE_INS_FRONT) ? '0 :
                                 (r_mode == plid_pkg::MODE_INS_BACK)  ? r_occ : w_pos_idx;
                        if (r_mode == plid_pkg::MODE_INS_POS && w_neg) begin
                            n_status = plid_pkg::ST_NEGATIVE;
                        end else if (w_full) begin
                            n_status = plid_pkg::ST_FULL;
                        end else if (r_mode == plid_pkg::MODE_INS_POS
                                     && w_pos_ext > w_occ_ext) begin
                            n_status = plid_pkg::ST_RANGE;
                        end
                    end
                    plid_pkg::MODE_DEL_FRONT, plid_pkg::MODE_DEL_BACK,
                    plid_pkg::MODE_DEL_POS: begin
                        n_ins  = 1'b0;
                        n_stop = r_occ;
                        n_idx  = (r_mode == plid_pkg::MODE_DEL_FRONT) ? OCC_W'(1) :
                                 (r_mode == plid_pkg::MODE_DEL_BACK)  ? r_occ :
                                 (w_pos_idx + OCC_W'(1));
                        if (w_empty) begin
                            n_status = plid_pkg::ST_EMPTY;
                        end else if (r_mode == plid_pkg::MODE_DEL_POS && w_neg) begin
                            n_status = plid_pkg::ST_NEGATIVE;
                        end else if (r_mode == plid_pkg::MODE_DEL_POS
                                     && !(w_pos_ext < w_occ_ext)) begin
                            n_status = plid_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                        n_status = plid_pkg::ST_OK;
                    end
                endcase
            end
            plid_pkg::S_SHIFT: begin
                n_wpend = w_more;
                if (w_more) begin
                    n_waddr = r_ins ? AW'(r_idx) : AW'(r_idx - OCC_W'(1));
                    n_idx   = w_idx_step;
                end
                if (!w_more && !r_wpend && !r_ins) begin
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            plid_pkg::S_PUT: begin
                n_occ = r_occ + OCC_W'(1);
            end
            plid_pkg::S_RD_FIRST: begin
                n_first = '0;
                n_last  = '0;
            end
            plid_pkg::S_RD_LAST: begin
                n_first = VW'(w_rdata);
            end
            plid_pkg::S_GRAB: begin
                n_last = VW'(w_rdata);
            end
            plid_pkg::S_DONE: begin
                if (w_rsp_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = CW'(r_occ);
                    n_out_first  = r_first;
                    n_out_last   = r_last;
                end
            end
            default: begin
                n_wpend = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plid_pkg::S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_wpend     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            r_wpend     <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_ins        <= n_ins;
        r_idx        <= n_idx;
        r_stop       <= n_stop;
        r_waddr      <= n_waddr;
        r_first      <= n_first;
        r_last       <= n_last;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_first  <= n_out_first;
        r_out_last   <= n_out_last;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.count       = r_out_count;
    assign o_rsp.first_value = r_out_first;
    assign o_rsp.last_value  = r_out_last;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `PLID_ASSERT_IMP(a_occ_bound, 1'b1, r_occ <= OCC_W'(CAPACITY))
    `PLID_ASSERT_IMP(a_wr_state, w_we, r_state == plid_pkg::S_SHIFT || r_state == plid_pkg::S_PUT)
    `PLID_ASSERT_NXT(a_cmd_decode, i_cmd.valid && i_cmd.ready, r_state == plid_pkg::S_DECODE)
    `PLID_ASSERT_IMP(a_empty_zero, r_state == plid_pkg::S_DONE && r_status == plid_pkg::ST_EMPTY, r_occ == '0)

endmodule
